// ===== hdl/dlts_pkg.sv =====
// Shared constants and types for the delta-list task scheduler.
package dlts_pkg;

	localparam int MAX_TASKS_DEF = 32;
	localparam int TIME_BITS_DEF = 16;

	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_ADD      = 2'd1;
	localparam logic [1:0] OP_DISPATCH = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOREADY  = 2'd2;

	// control from the sequencer to the insert unit
	typedef struct packed {
		logic start;   // latch new task, clear walk state
		logic step;    // one entry passes the insert point
	} ins_ctl_t;

endpackage

// ===== hdl/dlts_cell.sv =====
// One list entry of the scheduler chain, with head countdown logic.
module dlts_cell #(
	parameter int TIME_BITS = dlts_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 ld,
	input  logic                 tick,
	input  logic [7:0]           d_task,
	input  logic [TIME_BITS-1:0] d_delta,
	input  logic [TIME_BITS-1:0] d_period,
	input  logic                 d_ready,
	output logic [7:0]           q_task,
	output logic [TIME_BITS-1:0] q_delta,
	output logic [TIME_BITS-1:0] q_period,
	output logic                 q_ready
);

	logic [7:0]           task_q;
	logic [TIME_BITS-1:0] delta_q;
	logic [TIME_BITS-1:0] period_q;
	logic                 ready_q;
	logic [TIME_BITS-1:0] tick_delta;

	// count down unless ready; zero delta marks ready
	always_comb begin
		tick_delta = delta_q;
		if (!ready_q && delta_q != '0)
			tick_delta = delta_q - TIME_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			task_q   <= d_task;
			delta_q  <= d_delta;
			period_q <= d_period;
			ready_q  <= d_ready;
		end else if (tick) begin
			delta_q <= tick_delta;
			if (tick_delta == '0)
				ready_q <= 1'b1;
		end
	end

	assign q_task   = task_q;
	assign q_delta  = delta_q;
	assign q_period = period_q;
	assign q_ready  = ready_q;

endmodule

// ===== hdl/dlts_insert.sv =====
// Insert point at the tail of the rotating chain: merges a new task in order.
module dlts_insert #(
	parameter int TIME_BITS = dlts_pkg::TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dlts_pkg::ins_ctl_t   ctl,
	input  logic [7:0]           new_task,
	input  logic [TIME_BITS-1:0] new_delay,
	input  logic [TIME_BITS-1:0] new_period,
	input  logic                 x_valid,
	input  logic [7:0]           x_task,
	input  logic [TIME_BITS-1:0] x_delta,
	input  logic [TIME_BITS-1:0] x_period,
	input  logic                 x_ready,
	output logic [7:0]           o_task,
	output logic [TIME_BITS-1:0] o_delta,
	output logic [TIME_BITS-1:0] o_period,
	output logic                 o_ready
);

	logic [7:0]           task_q;
	logic [TIME_BITS-1:0] delay_q;
	logic [TIME_BITS-1:0] period_q;
	logic [TIME_BITS:0]   before_q;
	logic                 placed_q;
	logic [7:0]           h_task_q;
	logic [TIME_BITS-1:0] h_delta_q;
	logic [TIME_BITS-1:0] h_period_q;
	logic                 h_ready_q;
	logic [TIME_BITS:0]   through;
	logic                 take_x;
	logic [TIME_BITS-1:0] new_delta;

	assign through   = before_q + {1'b0, x_delta};
	assign take_x    = !placed_q && x_valid && (through < {1'b0, delay_q});
	assign new_delta = delay_q - before_q[TIME_BITS-1:0];

	always_comb begin
		if (placed_q) begin
			o_task   = h_task_q;
			o_delta  = h_delta_q;
			o_period = h_period_q;
			o_ready  = h_ready_q;
		end else if (take_x) begin
			o_task   = x_task;
			o_delta  = x_delta;
			o_period = x_period;
			o_ready  = x_ready;
		end else begin
			o_task   = task_q;
			o_delta  = new_delta;
			o_period = period_q;
			o_ready  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			placed_q <= 1'b0;
		end else if (ctl.start) begin
			placed_q <= 1'b0;
		end else if (ctl.step && !placed_q && !take_x) begin
			placed_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			task_q   <= new_task;
			delay_q  <= new_delay;
			period_q <= new_period;
			before_q <= '0;
		end else if (ctl.step) begin
			if (take_x)
				before_q <= through;
			h_task_q   <= x_task;
			h_period_q <= x_period;
			h_ready_q  <= x_ready;
			// follower of the new entry gives up the new delta
			h_delta_q  <= placed_q ? x_delta : x_delta - new_delta;
		end
	end

endmodule

// ===== hdl/delta_list_task_scheduler_unit.sv =====
// Top level of the delta-list task scheduler: cell chain plus sequencer.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall  | op, task_id, first_delay, repeat_period
//  out     | output    | out_valid / out_stall| fired, fired_task, status, queued
//
// Tick, unused op, full add, one-shot and empty dispatch finish without a rotation.
// Add: the whole chain rotates once past the insert
// point. Periodic dispatch: pop, then the same rotation.
// Reset clears the entry count and sequencer; entry storage is not cleared.
// in_stall is high while a rotation runs or a result waits behind out_stall.
module delta_list_task_scheduler_unit #(
	parameter int MAX_TASKS = dlts_pkg::MAX_TASKS_DEF,
	parameter int TIME_BITS = dlts_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [7:0]  task_id,
	input  logic [15:0] first_delay,
	input  logic [15:0] repeat_period,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        fired,
	output logic [7:0]  fired_task,
	output logic [1:0]  status,
	output logic [5:0]  queued
);

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int SW = $clog2(MAX_TASKS);

	typedef enum logic {S_IDLE, S_ROT} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic [SW-1:0]        step_q;
	logic                 out_valid_q;
	logic                 fired_q;
	logic [7:0]           fired_task_q;
	logic [1:0]           status_q;

	logic [7:0]           c_task   [MAX_TASKS];
	logic [TIME_BITS-1:0] c_delta  [MAX_TASKS];
	logic [TIME_BITS-1:0] c_period [MAX_TASKS];
	logic                 c_ready  [MAX_TASKS];

	logic [7:0]           o_task;
	logic [TIME_BITS-1:0] o_delta;
	logic [TIME_BITS-1:0] o_period;
	logic                 o_ready;

	logic                 accept;
	logic                 chain_ld;
	logic                 do_tick;
	logic                 do_pop;
	logic                 is_full;
	logic                 head_ok;
	logic                 x_valid;
	logic [7:0]           ins_task;
	logic [TIME_BITS-1:0] ins_delay;
	logic [TIME_BITS-1:0] ins_period;
	dlts_pkg::ins_ctl_t   ctl;

	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign is_full   = (count_q == CW'(MAX_TASKS));
	assign head_ok   = (count_q != '0) && c_ready[0];
	assign do_tick   = accept && op == dlts_pkg::OP_TICK && count_q != '0;
	assign do_pop    = accept && op == dlts_pkg::OP_DISPATCH && head_ok;
	assign chain_ld  = do_pop || state_q == S_ROT;
	assign x_valid   = CW'(step_q) < count_q;

	// new task comes from the input on add, from the popped head on dispatch
	always_comb begin
		if (op == dlts_pkg::OP_DISPATCH) begin
			ins_task   = c_task[0];
			ins_delay  = c_period[0];
			ins_period = c_period[0];
		end else begin
			ins_task   = task_id;
			ins_delay  = TIME_BITS'(first_delay);
			ins_period = TIME_BITS'(repeat_period);
		end
	end

	assign ctl.start = accept;
	assign ctl.step  = state_q == S_ROT;

	// chain: each cell loads its right neighbor; the tail loads the insert point
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		logic [7:0]           d_task;
		logic [TIME_BITS-1:0] d_delta;
		logic [TIME_BITS-1:0] d_period;
		logic                 d_ready;

		if (i == MAX_TASKS - 1) begin : g_tail
			assign d_task   = o_task;
			assign d_delta  = o_delta;
			assign d_period = o_period;
			assign d_ready  = o_ready;
		end else begin : g_body
			assign d_task   = c_task[i+1];
			assign d_delta  = c_delta[i+1];
			assign d_period = c_period[i+1];
			assign d_ready  = c_ready[i+1];
		end

		dlts_cell #(.TIME_BITS(TIME_BITS)) u_cell (
			.clk      (clk),
			.ld       (chain_ld),
			.tick     ((i == 0) && do_tick),
			.d_task   (d_task),
			.d_delta  (d_delta),
			.d_period (d_period),
			.d_ready  (d_ready),
			.q_task   (c_task[i]),
			.q_delta  (c_delta[i]),
			.q_period (c_period[i]),
			.q_ready  (c_ready[i])
		);
	end

	dlts_insert #(.TIME_BITS(TIME_BITS)) u_insert (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.new_task   (ins_task),
		.new_delay  (ins_delay),
		.new_period (ins_period),
		.x_valid    (x_valid),
		.x_task     (c_task[0]),
		.x_delta    (c_delta[0]),
		.x_period   (c_period[0]),
		.x_ready    (c_ready[0]),
		.o_task     (o_task),
		.o_delta    (o_delta),
		.o_period   (o_period),
		.o_ready    (o_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			fired_q      <= 1'b0;
			fired_task_q <= '0;
			status_q     <= dlts_pkg::ST_OK;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						fired_q      <= 1'b0;
						fired_task_q <= '0;
						status_q     <= dlts_pkg::ST_OK;
						step_q       <= '0;
						case (op)
							dlts_pkg::OP_ADD: begin
								if (is_full) begin
									status_q    <= dlts_pkg::ST_FULL;
									out_valid_q <= 1'b1;
								end else begin
									state_q <= S_ROT;
								end
							end
							dlts_pkg::OP_DISPATCH: begin
								if (head_ok) begin
									fired_q      <= 1'b1;
									fired_task_q <= c_task[0];
									count_q      <= count_q - CW'(1);
									if (c_period[0] != '0)
										state_q <= S_ROT;
									else
										out_valid_q <= 1'b1;
								end else begin
									status_q    <= dlts_pkg::ST_NOREADY;
									out_valid_q <= 1'b1;
								end
							end
							default: begin
								// tick is done in the head cell; unused op does nothing
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				S_ROT: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(MAX_TASKS - 1)) begin
						count_q     <= count_q + CW'(1);
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign fired      = fired_q;
	assign fired_task = fired_task_q;
	assign status     = status_q;
	assign queued     = 6'(count_q);

endmodule

// ===== bench/delta_list_task_scheduler_unit_tb.sv =====
// Self-checking testbench for the delta-list task scheduler unit.
module delta_list_task_scheduler_unit_tb;

	localparam int N_TASKS = dlts_pkg::MAX_TASKS_DEF;
	localparam int CYC_LIMIT = 1500000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  task_id;
		logic [15:0] first_delay;
		logic [15:0] repeat_period;
	} sched_req_t;

	typedef struct packed {
		logic       fired;
		logic [7:0] fired_task;
		logic [1:0] status;
		logic [5:0] queued;
	} sched_rsp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  op;
	logic [7:0]  task_id;
	logic [15:0] first_delay;
	logic [15:0] repeat_period;
	logic        out_valid;
	logic        out_stall;
	logic        fired;
	logic [7:0]  fired_task;
	logic [1:0]  status;
	logic [5:0]  queued;

	delta_list_task_scheduler_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .task_id(task_id), .first_delay(first_delay),
		.repeat_period(repeat_period),
		.out_valid(out_valid), .out_stall(out_stall),
		.fired(fired), .fired_task(fired_task), .status(status), .queued(queued)
	);

	// shadow copy of the delta list
	logic [7:0]  sh_task[N_TASKS];
	logic [15:0] sh_delta[N_TASKS];
	logic [15:0] sh_period[N_TASKS];
	logic        sh_ready[N_TASKS];
	int          sh_count;

	sched_req_t pending_reqs[$];
	sched_rsp_t expected_rsps[$];
	int  errors;
	int  cycles;
	int  send_idle_pct;
	int  recv_idle_pct;
	int  recv_hold;        // cycles left in a forced receiver hold-off
	bit  send_pause;       // sender waits for the list of expected results to drain
	bit  stim_done;

	initial clk = 1'b0;

	always #5 clk = ~clk;

	// sorted insert; walk sums are kept 32 bits wide so they never wrap
	function automatic void list_insert(logic [7:0] id, logic [15:0] delay,
			logic [15:0] period);
		logic [31:0] sum_prev;
		logic [31:0] sum_here;
		int pos;
		logic [15:0] d;
		sum_prev = 0;
		pos = 0;
		while (pos < sh_count) begin
			sum_here = sum_prev + sh_delta[pos];
			if (sum_here >= delay)
				break;
			sum_prev = sum_here;
			pos++;
		end
		d = 16'(32'(delay) - sum_prev);
		for (int j = sh_count; j > pos; j--) begin
			sh_task[j] = sh_task[j-1];
			sh_delta[j] = sh_delta[j-1];
			sh_period[j] = sh_period[j-1];
			sh_ready[j] = sh_ready[j-1];
		end
		sh_task[pos] = id;
		sh_delta[pos] = d;
		sh_period[pos] = period;
		sh_ready[pos] = 1'b0;
		sh_count++;
		if (pos + 1 < sh_count)
			sh_delta[pos+1] = sh_delta[pos+1] - d;
	endfunction

	function automatic sched_rsp_t schedule_step(sched_req_t r);
		sched_rsp_t rsp;
		logic [7:0] tid;
		logic [15:0] per;
		rsp = '0;
		case (r.op)
			dlts_pkg::OP_TICK: begin
				if (sh_count > 0) begin
					if (sh_delta[0] > 0 && !sh_ready[0])
						sh_delta[0]--;
					if (sh_delta[0] == 0)
						sh_ready[0] = 1'b1;
				end
			end
			dlts_pkg::OP_ADD: begin
				if (sh_count >= N_TASKS)
					rsp.status = dlts_pkg::ST_FULL;
				else
					list_insert(r.task_id, r.first_delay, r.repeat_period);
			end
			dlts_pkg::OP_DISPATCH: begin
				if (sh_count > 0 && sh_ready[0]) begin
					tid = sh_task[0];
					per = sh_period[0];
					for (int j = 0; j + 1 < sh_count; j++) begin
						sh_task[j] = sh_task[j+1];
						sh_delta[j] = sh_delta[j+1];
						sh_period[j] = sh_period[j+1];
						sh_ready[j] = sh_ready[j+1];
					end
					sh_count--;
					rsp.fired = 1'b1;
					rsp.fired_task = tid;
					if (per != 0)
						list_insert(tid, per, per);
				end else begin
					rsp.status = dlts_pkg::ST_NOREADY;
				end
			end
			default: ;
		endcase
		rsp.queued = 6'(sh_count);
		return rsp;
	endfunction

	function automatic sched_req_t mk_req(logic [1:0] o, logic [7:0] id,
			logic [15:0] dl, logic [15:0] pr);
		sched_req_t r;
		r.op = o;
		r.task_id = id;
		r.first_delay = dl;
		r.repeat_period = pr;
		return r;
	endfunction

	// random transaction: mostly small delays so tasks actually come due
	function automatic sched_req_t rand_req();
		int sel;
		logic [15:0] dl;
		logic [15:0] pr;
		sel = $urandom_range(99);
		dl = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
		case ($urandom_range(3))
			0: pr = 0;
			1: pr = 16'($urandom);
			default: pr = 16'($urandom_range(1, 8));
		endcase
		if (sel < 45)
			return mk_req(dlts_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
		else if (sel < 72)
			return mk_req(dlts_pkg::OP_ADD, 8'($urandom), dl, pr);
		else if (sel < 97)
			return mk_req(dlts_pkg::OP_DISPATCH, 8'($urandom), 16'($urandom),
				16'($urandom));
		return mk_req(OP_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom));
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
			@(posedge clk);
	endtask

	// driver: offers the head of pending_reqs, holds it while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= '0;
			task_id <= '0;
			first_delay <= '0;
			repeat_period <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_rsps.push_back(schedule_step(pending_reqs.pop_front()));
			end
			if (in_valid && in_stall) begin
				// hold the stalled transaction
			end else if (pending_reqs.size() > (in_valid && !in_stall ? 0 : 0)
					&& !send_pause && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				op <= pending_reqs[0].op;
				task_id <= pending_reqs[0].task_id;
				first_delay <= pending_reqs[0].first_delay;
				repeat_period <= pending_reqs[0].repeat_period;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		sched_rsp_t got;
		sched_rsp_t want;
		if (!arst_n) begin
			out_stall <= 1'b1;
			recv_hold <= 0;
		end else begin
			cycles <= cycles + 1;
			if (out_valid && !out_stall) begin
				got = {fired, fired_task, status, queued};
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.fired !== want.fired)
						$display("%0t: fired exp %0d got %0d", $time, want.fired, got.fired);
					if (got.fired_task !== want.fired_task)
						$display("%0t: fired_task exp %0d got %0d", $time,
							want.fired_task, got.fired_task);
					if (got.status !== want.status)
						$display("%0t: status exp %0d got %0d", $time, want.status, got.status);
					if (got.queued !== want.queued)
						$display("%0t: queued exp %0d got %0d", $time, want.queued, got.queued);
					if (got !== want)
						errors++;
				end
			end
			if (recv_hold > 0) begin
				recv_hold <= recv_hold - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// the in-flight item counts: pending_reqs head is popped only on acceptance
	initial begin
		sched_req_t r;
		errors = 0;
		cycles = 0;
		send_idle_pct = 35;
		recv_idle_pct = 59;
		send_pause = 1'b0;
		stim_done = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b1;
		op = '0;
		task_id = '0;
		first_delay = '0;
		repeat_period = '0;
		for (int j = 0; j < N_TASKS; j++) begin
			sh_task[j] = 0;
			sh_delta[j] = 0;
			sh_period[j] = 0;
			sh_ready[j] = 0;
		end
		sh_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty tick/dispatch, zero delay, ties, extremes, unused op
		pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'hff, 16'hffff, 16'hffff));
		pending_reqs.push_back(mk_req(OP_UNUSED, 8'hff, 16'hffff, 16'hffff));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_ADD, 8'hff, 16'h0000, 16'h0002));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_ADD, 8'h00, 16'hffff, 16'hffff));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_ADD, 8'h5a, 16'hffff, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'hff, 16'hffff, 16'hffff));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_ADD, 8'ha5, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000, 16'h0000));
		// fill to capacity and past it; the last adds find the list full
		for (int k = 0; k < N_TASKS; k++)
			pending_reqs.push_back(mk_req(dlts_pkg::OP_ADD, 8'(k),
				16'($urandom_range(3)), 16'h0000));
		pending_reqs.push_back(mk_req(dlts_pkg::OP_ADD, 8'h77, 16'h0001, 16'h0001));
		// long receiver hold-off while the sender keeps offering
		recv_hold = 400;
		for (int k = 0; k < 20; k++)
			pending_reqs.push_back(mk_req(dlts_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
		for (int k = 0; k < N_TASKS + 2; k++)
			pending_reqs.push_back(mk_req(dlts_pkg::OP_DISPATCH, 8'h00, 16'h0000,
				16'h0000));
		wait_drained();

		// sender pause until every expected result has come
		send_pause = 1'b1;
		wait_drained();
		send_pause = 1'b0;

		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				send_idle_pct = 59;
				recv_idle_pct = 35;
			end else if (phase == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < 400; k++) begin
				r = rand_req();
				pending_reqs.push_back(r);
				if (pending_reqs.size() > 16)
					while (pending_reqs.size() > 4)
						@(posedge clk);
			end
		end
		wait_drained();
		repeat (3 * N_TASKS + 10) @(posedge clk);
		stim_done = 1'b1;
	end

	// final verdict or timeout
	always @(posedge clk) begin
		if (stim_done) begin
			if (errors == 0 && expected_rsps.size() == 0)
				$display("delta_list_task_scheduler_unit regression: pass");
			else
				$display("delta_list_task_scheduler_unit regression: fail");
			$finish;
		end else if (cycles > CYC_LIMIT) begin
			$display("delta_list_task_scheduler_unit regression: fail");
			$finish;
		end
	end

endmodule
